// File: hdl/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants of the 2x2 box downsampler
// Pixel and pair-sum widths, register indexes, command codes and the
// command carried from the front end to the back end.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;
    localparam int unsigned CFG_W          = 12;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned PIX_W          = 16;
    localparam int unsigned PAIR_W         = PIX_W + 1;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam logic [CFG_W-1:0] DIM_RESET = 12'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_EMIT  = 1'b1
    } t_op;

    typedef struct packed {
        logic [PAIR_W-1:0] blue;
        logic [PAIR_W-1:0] green;
        logic [PAIR_W-1:0] red;
    } t_pair;

    typedef struct packed {
        t_op   op;
        logic  row_end;
        logic  frame_end;
        t_pair sums;
    } t_cmd;

    // Limits a frame dimension to the range [2, hi].
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned hi);
        int unsigned x;
        x = {20'd0, v};
        if (x < 2) begin
            return 2;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

// File: hdl/box_downsample_2x2.sv
// ----------------------------------------------------------------------------
// box_downsample_2x2: 2x2 box-filter downsampler for an RGB raster stream
// Throughput: one input pixel per cycle; the input stalls only when the command
// queue fills up behind an output beat that is held off.
// The closing pixel of a 2x2 block passes through the queue, the line-store read
// and the output register before its averaged beat is valid.
// Reset clears positions to the frame start and sets both dimensions to 2048
// (limited to the maximum); the line store is not cleared.
// ----------------------------------------------------------------------------
module box_downsample_2x2 #(
    parameter int unsigned MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bds_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bds_pkg::PIX_W-1:0]     i_red_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_green_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_blue_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bds_pkg::PIX_W-1:0]     o_red_out,
    output logic [bds_pkg::PIX_W-1:0]     o_green_out,
    output logic [bds_pkg::PIX_W-1:0]     o_blue_out,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bds_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned DEPTH  = MAX_WIDTH / 2;
    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned QW     = $bits(bds_pkg::t_cmd) + AW;

    logic          q_full, q_empty, push, pop;
    bds_pkg::t_cmd f_cmd, b_cmd;
    logic [AW-1:0] f_idx, b_idx;
    logic [QW-1:0] q_out;

    bds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_idx       (f_idx)
    );

    bds_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_idx}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign b_cmd = q_out[QW-1:AW];
    assign b_idx = q_out[AW-1:0];

    bds_back #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (b_cmd),
        .i_idx       (b_idx),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !pop)
        else $error("command popped from an empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_empty) |=> !q_empty)
        else $error("pushed command lost from the queue");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_row_end)
        else $error("frame end beat without row end");

endmodule

// File: hdl/bds_front.sv
// ----------------------------------------------------------------------------
// bds_front: pixel intake and classification
// Tracks the raster position, pairs even and odd columns into horizontal
// sums and issues store or emit commands to the command queue.
// ----------------------------------------------------------------------------
module bds_front #(
    parameter int unsigned MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bds_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned AW         = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bds_pkg::PIX_W-1:0]     i_red_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_green_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_blue_in,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bds_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output bds_pkg::t_cmd                 o_cmd,
    output logic [AW-1:0]                 o_idx
);

    localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [bds_pkg::PIX_W-1:0] r_pend_red, r_pend_green, r_pend_blue;

    logic          accept;
    logic          cfg_write;
    logic [WW-1:0] used_w;
    logic [HW-1:0] used_h;
    logic          in_active;
    logic          col_last, row_last;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Odd trailing column or row is dropped: only the even-sized part counts.
    assign used_w    = {r_width[WW-1:1], 1'b0};
    assign used_h    = {r_height[HW-1:1], 1'b0};
    assign in_active = (WW'(r_col) < used_w) && (HW'(r_row) < used_h);
    assign col_last  = (WW'(r_col) == r_width - WW'(1));
    assign row_last  = (HW'(r_row) == r_height - HW'(1));

    assign o_push = accept && in_active && r_col[0];
    assign o_idx  = AW'(r_col >> 1);

    always_comb begin
        o_cmd.op             = r_row[0] ? bds_pkg::OP_EMIT : bds_pkg::OP_STORE;
        o_cmd.row_end        = (WW'(r_col) == used_w - WW'(1));
        o_cmd.frame_end      = o_cmd.row_end && (HW'(r_row) == used_h - HW'(1));
        o_cmd.sums.red       = {1'b0, r_pend_red} + {1'b0, i_red_in};
        o_cmd.sums.green     = {1'b0, r_pend_green} + {1'b0, i_green_in};
        o_cmd.sums.blue      = {1'b0, r_pend_blue} + {1'b0, i_blue_in};
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(bds_pkg::clamp_dim(bds_pkg::DIM_RESET, MAX_WIDTH));
            r_height <= HW'(bds_pkg::clamp_dim(bds_pkg::DIM_RESET, MAX_HEIGHT));
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_write) begin
            unique case (bds_pkg::t_cfg_reg'(i_cfg_index))
                bds_pkg::CFG_FRAME_WIDTH: begin
                    r_width <= WW'(bds_pkg::clamp_dim(i_cfg_data, MAX_WIDTH));
                end
                bds_pkg::CFG_FRAME_HEIGHT: begin
                    r_height <= HW'(bds_pkg::clamp_dim(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            // Any register write restarts the frame.
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // The even-column pixel always arrives before it is used, so no reset.
    always_ff @(posedge i_clk) begin
        if (accept && !r_col[0]) begin
            r_pend_red   <= i_red_in;
            r_pend_green <= i_green_in;
            r_pend_blue  <= i_blue_in;
        end
    end

endmodule

// File: hdl/bds_queue.sv
// ----------------------------------------------------------------------------
// bds_queue: command queue between front and back end
// A small first-in first-out buffer of register entries.
// ----------------------------------------------------------------------------
module bds_queue #(
    parameter int unsigned DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int unsigned D   = bds_pkg::QUEUE_DEPTH;
    localparam int unsigned PW  = $clog2(D);
    localparam int unsigned CNW = $clog2(D + 1);

    logic [DATA_W-1:0] r_mem [D];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNW-1:0]    r_count;

    assign o_full  = (r_count == CNW'(D));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(D - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(D - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/bds_back.sv
// ----------------------------------------------------------------------------
// bds_back: line store and output stage
// Executes queued commands: stores pair sums of even rows, and for odd rows
// reads the stored sums, completes the 2x2 average and presents the beat.
// ----------------------------------------------------------------------------
module bds_back #(
    parameter int unsigned AW    = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  bds_pkg::t_cmd             i_cmd,
    input  logic [AW-1:0]             i_idx,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bds_pkg::PIX_W-1:0] o_red_out,
    output logic [bds_pkg::PIX_W-1:0] o_green_out,
    output logic [bds_pkg::PIX_W-1:0] o_blue_out,
    output logic                      o_row_end,
    output logic                      o_frame_end
);

    localparam int unsigned TW = bds_pkg::PAIR_W + 1;

    bds_pkg::t_pair r_store [DEPTH];
    bds_pkg::t_pair r_rd;
    bds_pkg::t_pair r_s1_sums;
    logic           r_s1_valid, r_s1_re, r_s1_fe;
    logic           r_out_valid;

    logic           s1_adv, s1_free, pop_emit;
    logic [TW-1:0]  tot_red, tot_green, tot_blue;

    assign s1_adv   = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign o_pop    = !i_empty && ((i_cmd.op == bds_pkg::OP_STORE) || s1_free);
    assign pop_emit = o_pop && (i_cmd.op == bds_pkg::OP_EMIT);
    assign o_valid  = r_out_valid;

    assign tot_red   = {1'b0, r_rd.red}   + {1'b0, r_s1_sums.red};
    assign tot_green = {1'b0, r_rd.green} + {1'b0, r_s1_sums.green};
    assign tot_blue  = {1'b0, r_rd.blue}  + {1'b0, r_s1_sums.blue};

    // Line store: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == bds_pkg::OP_STORE)) begin
            r_store[i_idx] <= i_cmd.sums;
        end
        if (pop_emit) begin
            r_rd <= r_store[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_emit) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_emit) begin
            r_s1_sums <= i_cmd.sums;
            r_s1_re   <= i_cmd.row_end;
            r_s1_fe   <= i_cmd.frame_end;
        end
        if (s1_adv && r_s1_valid) begin
            o_red_out   <= tot_red[TW-1:2];
            o_green_out <= tot_green[TW-1:2];
            o_blue_out  <= tot_blue[TW-1:2];
            o_row_end   <= r_s1_re;
            o_frame_end <= r_s1_fe;
        end
    end

endmodule
